// File: sv/pxh_pkg.sv
// Shared constants for the periodic x/y histogram: field widths, item codes,
// filter modes and configuration register indexes. No dependencies.
`default_nettype none

package pxh_pkg;

  // Field widths
  localparam int POS_W      = 32;
  localparam int LEN_W      = 31;
  localparam int GRID_W     = 7;
  localparam int BIN_W      = 6;
  localparam int CNT_W      = 32;
  localparam int FUNC_W     = 2;
  localparam int MODE_W     = 2;
  localparam int HCNT_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W     = GRID_W + LEN_W;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // Filter modes
  localparam logic [MODE_W-1:0] MODE_WRAP_Z = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ONE_H  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RAW_Z  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_LEN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_LEN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_LEN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAB_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAB_HIGH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_X     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd7;

  // Register reset values
  localparam logic [LEN_W-1:0]  RST_CELL_LEN  = 31'd65536;
  localparam logic [POS_W-1:0]  RST_SLAB_LOW  = 32'd0;
  localparam logic [POS_W-1:0]  RST_SLAB_HIGH = 32'd65536;
  localparam logic [GRID_W-1:0] RST_GRID      = 7'd64;

  // Count saturation value
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

endpackage : pxh_pkg

`default_nettype wire

// File: sv/pxh_in_if.sv
// Request channel of the periodic x/y histogram: valid/ready plus one item.
// Depends on pxh_pkg for the field widths.
`default_nettype none

interface pxh_in_if import pxh_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic [HCNT_W-1:0]        h_count;
  logic [BIN_W-1:0]         req_bin_x;
  logic [BIN_W-1:0]         req_bin_y;

  modport source (
    output valid, func, pos_x, pos_y, pos_z, h_count, req_bin_x, req_bin_y,
    input  ready
  );

  modport sink (
    input  valid, func, pos_x, pos_y, pos_z, h_count, req_bin_x, req_bin_y,
    output ready
  );

endinterface : pxh_in_if

`default_nettype wire

// File: sv/pxh_out_if.sv
// Result channel of the periodic x/y histogram: valid/ready plus one result.
// Depends on pxh_pkg for the field widths.
`default_nettype none

interface pxh_out_if import pxh_pkg::*; ();

  logic               valid;
  logic               ready;
  logic               accepted;
  logic [BIN_W-1:0]   bin_x_out;
  logic [BIN_W-1:0]   bin_y_out;
  logic [CNT_W-1:0]   bin_count;

  modport source (
    output valid, accepted, bin_x_out, bin_y_out, bin_count,
    input  ready
  );

  modport sink (
    input  valid, accepted, bin_x_out, bin_y_out, bin_count,
    output ready
  );

endinterface : pxh_out_if

`default_nettype wire

// File: sv/pxh_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module pxh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule : pxh_ram

`default_nettype wire

// File: sv/periodic_xy_histogram_top.sv
// Periodic x/y histogram top level: sequencer, shared subtract unit and count RAM.
// Depends on pxh_pkg, pxh_in_if, pxh_out_if and pxh_ram.
//
// Usage:
//  - in_i carries one request a cycle at most: add an atom, read a bin or clear
//    a bin. out_o returns exactly one result for every request, in order.
//  - cfg_we_i/cfg_idx_i/cfg_data_i write one register a cycle; write only while
//    no request is in flight.
//  - One request is worked on at a time; in_i.ready is high only when idle.
//    The remainders and bin divisions run through one shared subtractor, one
//    bit a cycle: each wrap is a load, 32 remainder steps and a sign fix-up,
//    and each bin adds a multiply and 7 quotient steps.
//  - Add in mode 0 wraps z, tests the slab, then bins x and y; mode 1 bins x
//    and y only when h_count is one; mode 2 tests the raw z, then bins x and y.
//  - The result sits in an output register; a stalled receiver holds it there,
//    and the next request may be accepted and worked on meanwhile, waiting at
//    the end until the register is free.
//  - After reset the count RAM is swept to zero, one entry a cycle, over all
//    MAX_GRID_X*MAX_GRID_Y entries (4096 by default); no request is accepted
//    during the sweep, but configuration writes are.
`default_nettype none

module periodic_xy_histogram_top
  import pxh_pkg::*;
#(
  parameter int MAX_GRID_X = 64,
  parameter int MAX_GRID_Y = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pxh_in_if.sink                in_i,
  pxh_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int DEPTH = MAX_GRID_X * MAX_GRID_Y;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int STEP_W = $clog2(POS_W);

  // Sequencer states
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_LOAD  = 4'd2;
  localparam logic [3:0] ST_MOD   = 4'd3;
  localparam logic [3:0] ST_FIX   = 4'd4;
  localparam logic [3:0] ST_SLAB  = 4'd5;
  localparam logic [3:0] ST_MUL   = 4'd6;
  localparam logic [3:0] ST_BIN   = 4'd7;
  localparam logic [3:0] ST_READ  = 4'd8;
  localparam logic [3:0] ST_UPD   = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;

  // Axis under work
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // Configuration registers
  logic [LEN_W-1:0]        cell_len_x_q, cell_len_y_q, cell_len_z_q;
  logic signed [POS_W-1:0] slab_low_q, slab_high_q;
  logic [GRID_W-1:0]       grid_x_q, grid_y_q;
  logic [MODE_W-1:0]       select_mode_q;

  // Control state
  logic [3:0]        state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              out_valid_q, out_valid_d;

  // Working registers
  logic [FUNC_W-1:0]       func_q, func_d;
  logic [POS_W-1:0]        pos_x_q, pos_x_d, pos_y_q, pos_y_d, pos_z_q, pos_z_d;
  logic [1:0]              axis_q, axis_d;
  logic [POS_W-1:0]        dvd_q, dvd_d;
  logic                    neg_q, neg_d;
  logic [PROD_W-1:0]       rem_q, rem_d;
  logic [STEP_W-1:0]       cnt_q, cnt_d;
  logic [GRID_W-1:0]       quot_q, quot_d;
  logic [GRID_W-1:0]       ix_q, ix_d, iy_q, iy_d;
  logic signed [POS_W:0]   slab_val_q, slab_val_d;
  logic                    res_acc_q, res_acc_d;
  logic [CNT_W-1:0]        res_cnt_q, res_cnt_d;

  // Output registers
  logic              out_acc_q, out_acc_d;
  logic [BIN_W-1:0]  out_bx_q, out_bx_d, out_by_q, out_by_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;

  // Datapath signals
  logic [GRID_W-1:0]     gx_eff, gy_eff, g_sel;
  logic [LEN_W-1:0]      len_sel;
  logic [POS_W-1:0]      pos_sel;
  logic [PROD_W-1:0]     op_a, op_b;
  logic [PROD_W:0]       diff;
  logic                  no_borrow;
  logic [PROD_W-1:0]     prod;
  logic [LEN_W-1:0]      wrapped;
  logic                  slab_pass;
  logic signed [POS_W:0] lo_ext, hi_ext;
  logic [AW-1:0]         bin_addr;
  logic [CNT_W-1:0]      ram_rdata, new_cnt;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [CNT_W-1:0]      ram_wdata;
  logic                  in_fire;
  logic                  in_range;

  // Clamp grid sizes into [1, MAX]
  always_comb begin
    if (grid_x_q == '0) begin
      gx_eff = GRID_W'(1);
    end else if (int'(grid_x_q) > MAX_GRID_X) begin
      gx_eff = GRID_W'(MAX_GRID_X);
    end else begin
      gx_eff = grid_x_q;
    end
    if (grid_y_q == '0) begin
      gy_eff = GRID_W'(1);
    end else if (int'(grid_y_q) > MAX_GRID_Y) begin
      gy_eff = GRID_W'(MAX_GRID_Y);
    end else begin
      gy_eff = grid_y_q;
    end
  end

  // Select cell length, position and grid for the axis under work
  always_comb begin
    case (axis_q)
      AX_X: begin
        len_sel = cell_len_x_q;
        pos_sel = pos_x_q;
      end
      AX_Y: begin
        len_sel = cell_len_y_q;
        pos_sel = pos_y_q;
      end
      default: begin
        len_sel = cell_len_z_q;
        pos_sel = pos_z_q;
      end
    endcase
    // A zero length counts as one
    if (len_sel == '0) begin
      len_sel = LEN_W'(1);
    end
    g_sel = (axis_q == AX_X) ? gx_eff : gy_eff;
  end

  // Shared subtract/compare unit
  always_comb begin
    case (state_q)
      ST_MOD: begin
        op_a = PROD_W'({rem_q[LEN_W-1:0], dvd_q[POS_W-1]});
        op_b = PROD_W'(len_sel);
      end
      ST_FIX: begin
        op_a = PROD_W'(len_sel);
        op_b = PROD_W'(rem_q[LEN_W-1:0]);
      end
      default: begin
        op_a = rem_q;
        op_b = PROD_W'(len_sel) << cnt_q[2:0];
      end
    endcase
  end

  assign diff      = {1'b0, op_a} - {1'b0, op_b};
  assign no_borrow = ~diff[PROD_W];

  // Scale the wrapped coordinate by the grid size
  assign prod = PROD_W'(g_sel) * PROD_W'(rem_q[LEN_W-1:0]);

  // Floored remainder: a non-zero remainder of a negative value folds up
  assign wrapped = (neg_q && (rem_q[LEN_W-1:0] != '0)) ? diff[LEN_W-1:0]
                                                       : rem_q[LEN_W-1:0];

  // Open slab test on the stored z value
  assign lo_ext    = {slab_low_q[POS_W-1], slab_low_q};
  assign hi_ext    = {slab_high_q[POS_W-1], slab_high_q};
  assign slab_pass = (slab_val_q > lo_ext) && (slab_val_q < hi_ext);

  // Bin address, row-major over the maximum grid
  assign bin_addr = AW'(int'(iy_q) * MAX_GRID_X + int'(ix_q));

  assign in_fire  = in_i.valid && in_i.ready;
  assign in_range = ({1'b0, in_i.req_bin_x} < gx_eff) && ({1'b0, in_i.req_bin_y} < gy_eff);

  // Count update for the current request
  always_comb begin
    case (func_q)
      FUNC_ADD:   new_cnt = (ram_rdata == CNT_MAX) ? ram_rdata : ram_rdata + CNT_W'(1);
      FUNC_CLEAR: new_cnt = '0;
      default:    new_cnt = ram_rdata;
    endcase
  end

  // Sequencer
  always_comb begin
    logic [GRID_W-1:0] quot_nxt;

    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    func_d      = func_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    pos_z_d     = pos_z_q;
    axis_d      = axis_q;
    dvd_d       = dvd_q;
    neg_d       = neg_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    quot_d      = quot_q;
    ix_d        = ix_q;
    iy_d        = iy_q;
    slab_val_d  = slab_val_q;
    res_acc_d   = res_acc_q;
    res_cnt_d   = res_cnt_q;
    out_acc_d   = out_acc_q;
    out_bx_d    = out_bx_q;
    out_by_d    = out_by_q;
    out_cnt_d   = out_cnt_q;
    ram_we      = 1'b0;
    ram_waddr   = bin_addr;
    ram_wdata   = new_cnt;
    quot_nxt    = quot_q;

    // Drop the result once the receiver takes it
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      // Sweep the count RAM to zero after reset
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      // Take a request and pick the first step
      ST_IDLE: begin
        if (in_fire) begin
          func_d    = in_i.func;
          pos_x_d   = in_i.pos_x;
          pos_y_d   = in_i.pos_y;
          pos_z_d   = in_i.pos_z;
          axis_d    = AX_X;
          res_acc_d = 1'b0;
          res_cnt_d = '0;
          ix_d      = '0;
          iy_d      = '0;
          state_d   = ST_DONE;
          case (in_i.func)
            FUNC_ADD: begin
              case (select_mode_q)
                MODE_WRAP_Z: begin
                  axis_d  = AX_Z;
                  state_d = ST_LOAD;
                end
                MODE_ONE_H: begin
                  if (in_i.h_count == HCNT_W'(1)) begin
                    state_d = ST_LOAD;
                  end
                end
                MODE_RAW_Z: begin
                  slab_val_d = {in_i.pos_z[POS_W-1], in_i.pos_z};
                  state_d    = ST_SLAB;
                end
                default: begin
                  state_d = ST_DONE;
                end
              endcase
            end
            FUNC_READ, FUNC_CLEAR: begin
              ix_d = GRID_W'(in_i.req_bin_x);
              iy_d = GRID_W'(in_i.req_bin_y);
              if (in_range) begin
                state_d = ST_READ;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      // Load the magnitude of the coordinate for the remainder
      ST_LOAD: begin
        dvd_d   = pos_sel[POS_W-1] ? (~pos_sel + POS_W'(1)) : pos_sel;
        neg_d   = pos_sel[POS_W-1];
        rem_d   = '0;
        cnt_d   = '0;
        state_d = ST_MOD;
      end

      // One restoring remainder step a cycle
      ST_MOD: begin
        rem_d = no_borrow ? diff[PROD_W-1:0] : op_a;
        dvd_d = dvd_q << 1;
        cnt_d = cnt_q + STEP_W'(1);
        if (cnt_q == STEP_W'(POS_W - 1)) begin
          state_d = ST_FIX;
        end
      end

      // Fold the remainder for negative coordinates
      ST_FIX: begin
        if (axis_q == AX_Z) begin
          slab_val_d = {2'b00, wrapped};
          state_d    = ST_SLAB;
        end else begin
          rem_d   = PROD_W'(wrapped);
          state_d = ST_MUL;
        end
      end

      // Keep the atom only inside the slab
      ST_SLAB: begin
        if (slab_pass) begin
          axis_d  = AX_X;
          state_d = ST_LOAD;
        end else begin
          state_d = ST_DONE;
        end
      end

      // Scale by the grid, then divide by the cell length
      ST_MUL: begin
        rem_d   = prod;
        quot_d  = '0;
        cnt_d   = STEP_W'(GRID_W - 1);
        state_d = ST_BIN;
      end

      // One quotient bit a cycle, most significant first
      ST_BIN: begin
        if (no_borrow) begin
          rem_d                = diff[PROD_W-1:0];
          quot_nxt[cnt_q[2:0]] = 1'b1;
        end
        quot_d = quot_nxt;
        cnt_d  = cnt_q - STEP_W'(1);
        if (cnt_q == '0) begin
          if (axis_q == AX_X) begin
            ix_d    = quot_nxt;
            axis_d  = AX_Y;
            state_d = ST_LOAD;
          end else begin
            iy_d      = quot_nxt;
            res_acc_d = 1'b1;
            state_d   = ST_READ;
          end
        end
      end

      // Address presented to the RAM; data arrives next cycle
      ST_READ: begin
        state_d = ST_UPD;
      end

      // Write back the updated count, except for a read
      ST_UPD: begin
        ram_we    = (func_q != FUNC_READ);
        res_cnt_d = new_cnt;
        state_d   = ST_DONE;
      end

      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_acc_d   = res_acc_q;
          out_bx_d    = ix_q[BIN_W-1:0];
          out_by_d    = iy_q[BIN_W-1:0];
          out_cnt_d   = res_cnt_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_len_x_q  <= RST_CELL_LEN;
      cell_len_y_q  <= RST_CELL_LEN;
      cell_len_z_q  <= RST_CELL_LEN;
      slab_low_q    <= RST_SLAB_LOW;
      slab_high_q   <= RST_SLAB_HIGH;
      grid_x_q      <= RST_GRID;
      grid_y_q      <= RST_GRID;
      select_mode_q <= MODE_WRAP_Z;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CELL_LEN_X: cell_len_x_q  <= cfg_data_i[LEN_W-1:0];
        CFG_CELL_LEN_Y: cell_len_y_q  <= cfg_data_i[LEN_W-1:0];
        CFG_CELL_LEN_Z: cell_len_z_q  <= cfg_data_i[LEN_W-1:0];
        CFG_SLAB_LOW:   slab_low_q    <= cfg_data_i[POS_W-1:0];
        CFG_SLAB_HIGH:  slab_high_q   <= cfg_data_i[POS_W-1:0];
        CFG_GRID_X:     grid_x_q      <= cfg_data_i[GRID_W-1:0];
        CFG_GRID_Y:     grid_y_q      <= cfg_data_i[GRID_W-1:0];
        CFG_MODE:       select_mode_q <= cfg_data_i[MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    pos_x_q    <= pos_x_d;
    pos_y_q    <= pos_y_d;
    pos_z_q    <= pos_z_d;
    axis_q     <= axis_d;
    dvd_q      <= dvd_d;
    neg_q      <= neg_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    quot_q     <= quot_d;
    ix_q       <= ix_d;
    iy_q       <= iy_d;
    slab_val_q <= slab_val_d;
    res_acc_q  <= res_acc_d;
    res_cnt_q  <= res_cnt_d;
    out_acc_q  <= out_acc_d;
    out_bx_q   <= out_bx_d;
    out_by_q   <= out_by_d;
    out_cnt_q  <= out_cnt_d;
  end

  // Count store
  pxh_ram #(
    .WIDTH (CNT_W),
    .DEPTH (DEPTH)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (bin_addr),
    .rdata_o (ram_rdata)
  );

  // Channel outputs
  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.accepted  = out_acc_q;
  assign out_o.bin_x_out = out_bx_q;
  assign out_o.bin_y_out = out_by_q;
  assign out_o.bin_count = out_cnt_q;

endmodule : periodic_xy_histogram_top

`default_nettype wire
